>>> design/rtpst_pkg.sv
// ----------------------------------------------------------------------------
// rtpst_pkg
// Shared widths, event codes, register map and entry layout for the RTP
// sequence tracker.
// ----------------------------------------------------------------------------
package rtpst_pkg;

   localparam int NUM_SOURCES = 64;
   localparam int ADDR_W      = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;

   localparam int SRC_W  = 6;
   localparam int SEQ_W  = 16;
   localparam int CAND_W = 17;
   localparam int CNT_W  = 32;
   localparam int KIND_W = 3;
   localparam int DATA_W = 32;
   localparam int PADDR_W = 3;

   localparam logic [SEQ_W-1:0]  GAP_LIMIT_RST      = 16'd3000;
   localparam logic [SEQ_W-1:0]  REORDER_WINDOW_RST = 16'd100;
   localparam logic [CAND_W-1:0] NO_CANDIDATE       = 17'h10001;
   localparam logic [CAND_W-1:0] SEQ_SPAN           = 17'h10000;

   // register index, taken from paddr[2]
   localparam logic REG_GAP_LIMIT      = 1'b0;
   localparam logic REG_REORDER_WINDOW = 1'b1;

   // word mode
   localparam logic MODE_PACKET = 1'b0;
   localparam logic MODE_CLEAR  = 1'b1;

   localparam logic [KIND_W-1:0] EV_FIRST     = 3'd0;
   localparam logic [KIND_W-1:0] EV_IN_ORDER  = 3'd1;
   localparam logic [KIND_W-1:0] EV_WRAPPED   = 3'd2;
   localparam logic [KIND_W-1:0] EV_RESYNC    = 3'd3;
   localparam logic [KIND_W-1:0] EV_REJECTED  = 3'd4;
   localparam logic [KIND_W-1:0] EV_DUPLICATE = 3'd5;
   localparam logic [KIND_W-1:0] EV_MISORDER  = 3'd6;
   localparam logic [KIND_W-1:0] EV_CLEARED   = 3'd7;

   typedef struct packed {
      logic [SEQ_W-1:0]  base_seq;
      logic [SEQ_W-1:0]  highest_seq;
      logic [CAND_W-1:0] candidate;
      logic [SEQ_W-1:0]  wrap_count;
      logic [CNT_W-1:0]  received;
      logic [CNT_W-1:0]  duplicates;
      logic [CNT_W-1:0]  misordered;
   } entry_type;

   typedef struct packed {
      logic             mode;
      logic [SRC_W-1:0] source_index;
      logic [SEQ_W-1:0] sequence_number;
   } req_item_type;

   typedef struct packed {
      logic              write;
      logic              accepted;
      logic [KIND_W-1:0] kind;
   } upd_status_type;

endpackage

>>> design/rtpst_channel_if.sv
// ----------------------------------------------------------------------------
// rtpst channel interfaces
// Valid/ready channels for packet words in and per-source status words out.
// ----------------------------------------------------------------------------
interface rtpst_req_if;
   import rtpst_pkg::*;

   logic             valid;
   logic             ready;
   logic             mode;
   logic [SRC_W-1:0] source_index;
   logic [SEQ_W-1:0] sequence_number;

   modport source (output valid, mode, source_index, sequence_number, input ready);
   modport sink   (input valid, mode, source_index, sequence_number, output ready);
endinterface

interface rtpst_rsp_if;
   import rtpst_pkg::*;

   logic              valid;
   logic              ready;
   logic              accepted;
   logic [KIND_W-1:0] event_kind;
   logic [CNT_W-1:0]  extended_highest_seq;
   logic [SEQ_W-1:0]  first_seq;
   logic [CNT_W-1:0]  received_total;
   logic [CNT_W-1:0]  duplicate_total;
   logic [CNT_W-1:0]  misordered_total;

   modport source (output valid, accepted, event_kind, extended_highest_seq, first_seq,
                   received_total, duplicate_total, misordered_total, input ready);
   modport sink   (input valid, accepted, event_kind, extended_highest_seq, first_seq,
                   received_total, duplicate_total, misordered_total, output ready);
endinterface

>>> design/rtpst_csr.sv
// ----------------------------------------------------------------------------
// rtpst_csr
// APB register file holding the dropout and misorder thresholds.
// ----------------------------------------------------------------------------
module rtpst_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [rtpst_pkg::PADDR_W-1:0] paddr,
   input  logic [rtpst_pkg::DATA_W-1:0]  pwdata,
   output logic [rtpst_pkg::DATA_W-1:0]  prdata,
   output logic                          pready,
   output logic [rtpst_pkg::SEQ_W-1:0]   gap_limit,
   output logic [rtpst_pkg::SEQ_W-1:0]   reorder_window
);
   import rtpst_pkg::*;

   logic [SEQ_W-1:0] gap_limit_ff;
   logic [SEQ_W-1:0] reorder_window_ff;
   logic             wr_strobe;

   assign pready    = 1'b1;
   assign wr_strobe = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_limit_ff      <= GAP_LIMIT_RST;
         reorder_window_ff <= REORDER_WINDOW_RST;
      end else if (wr_strobe) begin
         unique case (paddr[2])
            REG_GAP_LIMIT:      gap_limit_ff      <= pwdata[SEQ_W-1:0];
            REG_REORDER_WINDOW: reorder_window_ff <= pwdata[SEQ_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_GAP_LIMIT:      prdata = {{(DATA_W-SEQ_W){1'b0}}, gap_limit_ff};
         REG_REORDER_WINDOW: prdata = {{(DATA_W-SEQ_W){1'b0}}, reorder_window_ff};
         default:            prdata = '0;
      endcase
   end

   assign gap_limit      = gap_limit_ff;
   assign reorder_window = reorder_window_ff;

endmodule

>>> design/rtpst_entry_ram.sv
// ----------------------------------------------------------------------------
// rtpst_entry_ram
// Per-source entry memory with a registered read, with per-entry valid
// flags so that reset empties the table at once, and a bypass from the
// write port into the read register.
// ----------------------------------------------------------------------------
module rtpst_entry_ram (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         rd_en,
   input  logic [rtpst_pkg::ADDR_W-1:0]  rd_addr,
   output rtpst_pkg::entry_type          rd_data,
   input  logic                         wr_en,
   input  logic [rtpst_pkg::ADDR_W-1:0]  wr_addr,
   input  rtpst_pkg::entry_type          wr_data
);
   import rtpst_pkg::*;

   entry_type              mem [NUM_SOURCES];
   logic [NUM_SOURCES-1:0] valid_ff;
   entry_type              rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // same-entry write in this cycle wins over the stale array word
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else if (valid_ff[rd_addr]) begin
            rd_data_ff <= mem[rd_addr];
         end else begin
            rd_data_ff <= '0;
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/rtpst_update.sv
// ----------------------------------------------------------------------------
// rtpst_update
// Sequence validation for one packet against its source entry: classifies
// the packet and forms the entry to write back.
// ----------------------------------------------------------------------------
module rtpst_update (
   input  rtpst_pkg::req_item_type      item,
   input  rtpst_pkg::entry_type         entry_in,
   input  logic [rtpst_pkg::SEQ_W-1:0]  gap_limit,
   input  logic [rtpst_pkg::SEQ_W-1:0]  reorder_window,
   output rtpst_pkg::entry_type         entry_out,
   output rtpst_pkg::entry_type         entry_shown,
   output rtpst_pkg::upd_status_type    status
);
   import rtpst_pkg::*;

   logic [SEQ_W-1:0]  seq;
   logic [SEQ_W-1:0]  gap;
   logic [CAND_W-1:0] jump_limit;
   logic              in_range;

   assign seq        = item.sequence_number;
   assign gap        = seq - entry_in.highest_seq;
   assign jump_limit = SEQ_SPAN - {1'b0, reorder_window};
   assign in_range   = (int'(item.source_index) < NUM_SOURCES);

   always_comb begin
      entry_out       = entry_in;
      status.write    = 1'b0;
      status.accepted = 1'b0;
      status.kind     = EV_REJECTED;
      if (!in_range) begin
         status.write = 1'b0;
      end else if (item.mode == MODE_CLEAR) begin
         entry_out   = '0;
         status.write = 1'b1;
         status.kind  = EV_CLEARED;
      end else if (entry_in.received == '0) begin
         entry_out.base_seq    = seq;
         entry_out.highest_seq = seq;
         entry_out.candidate   = NO_CANDIDATE;
         entry_out.wrap_count  = '0;
         entry_out.received    = CNT_W'(1);
         status.write    = 1'b1;
         status.accepted = 1'b1;
         status.kind     = EV_FIRST;
      end else if (gap < gap_limit) begin
         if (seq < entry_in.highest_seq) begin
            entry_out.wrap_count = entry_in.wrap_count + SEQ_W'(1);
            status.kind = EV_WRAPPED;
         end else begin
            status.kind = EV_IN_ORDER;
         end
         entry_out.highest_seq = seq;
         entry_out.received    = entry_in.received + CNT_W'(1);
         status.write    = 1'b1;
         status.accepted = 1'b1;
      end else if ({1'b0, gap} <= jump_limit) begin
         status.write = 1'b1;
         if ({1'b0, seq} == entry_in.candidate) begin
            // second packet of a jump confirms the new numbering
            entry_out.base_seq    = seq;
            entry_out.highest_seq = seq;
            entry_out.candidate   = NO_CANDIDATE;
            entry_out.wrap_count  = '0;
            entry_out.received    = CNT_W'(1);
            status.accepted = 1'b1;
            status.kind     = EV_RESYNC;
         end else begin
            entry_out.candidate = {1'b0, seq + SEQ_W'(1)};
            status.kind         = EV_REJECTED;
         end
      end else begin
         if (gap == '0) begin
            entry_out.duplicates = entry_in.duplicates + CNT_W'(1);
            status.kind = EV_DUPLICATE;
         end else begin
            entry_out.misordered = entry_in.misordered + CNT_W'(1);
            status.kind = EV_MISORDER;
         end
         entry_out.received = entry_in.received + CNT_W'(1);
         status.write    = 1'b1;
         status.accepted = 1'b1;
      end
   end

   assign entry_shown = in_range ? entry_out : '0;

endmodule

>>> design/rtp_sequence_tracker_unit.sv
// ----------------------------------------------------------------------------
// rtp_sequence_tracker_unit
// RTP sequence number validation over a table of 64 sources.
// ----------------------------------------------------------------------------
// Takes one packet word per clock unless the output stalls, and returns one
// status word per packet, in order, through the update stage and output
// register. Each source entry lives in a 64-deep memory with a registered
// read; the entry is read on acceptance, updated in the update stage and
// written back as the word leaves; a write to the same entry is bypassed
// into the read register so that consecutive words for one source see each
// other's updates. The read-modify-write sets the rate of one word per
// cycle. Per-entry valid flags empty the table on reset, so no clearing pass
// is needed and words are taken right after reset. The user must write
// thresholds over APB only while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
module rtp_sequence_tracker_unit (
   input  logic                          clock,
   input  logic                          reset,
   rtpst_req_if.sink                     req_ch,
   rtpst_rsp_if.source                   rsp_ch,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [rtpst_pkg::PADDR_W-1:0] paddr,
   input  logic [rtpst_pkg::DATA_W-1:0]  pwdata,
   output logic [rtpst_pkg::DATA_W-1:0]  prdata,
   output logic                          pready
);
   import rtpst_pkg::*;

   logic [SEQ_W-1:0] gap_limit;
   logic [SEQ_W-1:0] reorder_window;

   req_item_type   req_item;
   logic           req_fire;
   logic           advance;
   logic           s1_fire;
   logic           s1_valid_ff;
   req_item_type   s1_item_ff;

   entry_type      rd_entry;
   entry_type      new_entry;
   entry_type      shown_entry;
   upd_status_type upd_status;
   logic           wr_en;

   logic              rsp_valid_ff;
   logic              rsp_accepted_ff;
   logic [KIND_W-1:0] rsp_kind_ff;
   entry_type         rsp_entry_ff;

   rtpst_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .gap_limit      (gap_limit),
      .reorder_window (reorder_window)
   );

   assign req_item.mode            = req_ch.mode;
   assign req_item.source_index    = req_ch.source_index;
   assign req_item.sequence_number = req_ch.sequence_number;

   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign s1_fire      = s1_valid_ff && advance;
   assign req_ch.ready = !s1_valid_ff || advance;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign wr_en        = s1_fire && upd_status.write;

   rtpst_entry_ram u_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_fire),
      .rd_addr (req_ch.source_index[ADDR_W-1:0]),
      .rd_data (rd_entry),
      .wr_en   (wr_en),
      .wr_addr (s1_item_ff.source_index[ADDR_W-1:0]),
      .wr_data (new_entry)
   );

   rtpst_update u_update (
      .item           (s1_item_ff),
      .entry_in       (rd_entry),
      .gap_limit      (gap_limit),
      .reorder_window (reorder_window),
      .entry_out      (new_entry),
      .entry_shown    (shown_entry),
      .status         (upd_status)
   );

   // update stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         s1_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_item_ff <= req_item;
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_accepted_ff <= upd_status.accepted;
         rsp_kind_ff     <= upd_status.kind;
         rsp_entry_ff    <= shown_entry;
      end
   end

   assign rsp_ch.valid                = rsp_valid_ff;
   assign rsp_ch.accepted             = rsp_accepted_ff;
   assign rsp_ch.event_kind           = rsp_kind_ff;
   assign rsp_ch.extended_highest_seq = {rsp_entry_ff.wrap_count, rsp_entry_ff.highest_seq};
   assign rsp_ch.first_seq            = rsp_entry_ff.base_seq;
   assign rsp_ch.received_total       = rsp_entry_ff.received;
   assign rsp_ch.duplicate_total      = rsp_entry_ff.duplicates;
   assign rsp_ch.misordered_total     = rsp_entry_ff.misordered;

`ifndef SYNTHESIS
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> (s1_valid_ff && $stable(s1_item_ff)))
      else $error("update stage lost or changed a held word");

   a_first_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && ((rsp_kind_ff == EV_FIRST) || (rsp_kind_ff == EV_RESYNC)))
         |-> (rsp_entry_ff.received == CNT_W'(1)))
      else $error("initialized entry does not show one received packet");

   a_reject_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && ((rsp_kind_ff == EV_REJECTED) || (rsp_kind_ff == EV_CLEARED)))
         |-> !rsp_accepted_ff)
      else $error("rejected or cleared word marked accepted");

   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_kind_ff == EV_CLEARED)) |-> (rsp_entry_ff == '0))
      else $error("cleared entry not shown as zero");
`endif

endmodule

>>> tb/rtpst_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtpst_tb_pkg
// Status word layout and scoreboard for the RTP sequence tracker bench: keeps
// its own per-source table, predicts the status word of every packet word
// and checks the words that come back, in order.
// ----------------------------------------------------------------------------
package rtpst_tb_pkg;
   import rtpst_pkg::*;

   localparam int   MAX_REPORTS = 10;

   typedef struct packed {
      logic              accepted;
      logic [KIND_W-1:0] kind;
      logic [CNT_W-1:0]  ext_highest;
      logic [SEQ_W-1:0]  first_seq;
      logic [CNT_W-1:0]  received;
      logic [CNT_W-1:0]  duplicates;
      logic [CNT_W-1:0]  misordered;
   } tracker_status_type;

   class seq_status_scoreboard;
      logic [SEQ_W-1:0]   dropout_limit;
      logic [SEQ_W-1:0]   misorder_window;
      logic [SEQ_W-1:0]   base_seq [NUM_SOURCES];
      logic [SEQ_W-1:0]   high_seq [NUM_SOURCES];
      logic [CAND_W-1:0]  candidate [NUM_SOURCES];
      logic [SEQ_W-1:0]   wraps [NUM_SOURCES];
      logic [CNT_W-1:0]   rcv_cnt [NUM_SOURCES];
      logic [CNT_W-1:0]   dup_cnt [NUM_SOURCES];
      logic [CNT_W-1:0]   mis_cnt [NUM_SOURCES];
      tracker_status_type expected_status_q [$];
      int unsigned        error_count;
      int unsigned        word_count;

      function new();
         dropout_limit   = GAP_LIMIT_RST;
         misorder_window = REORDER_WINDOW_RST;
         error_count     = 0;
         word_count      = 0;
         foreach (base_seq[i]) begin
            base_seq[i]  = '0;
            high_seq[i]  = '0;
            candidate[i] = '0;
            wraps[i]     = '0;
            rcv_cnt[i]   = '0;
            dup_cnt[i]   = '0;
            mis_cnt[i]   = '0;
         end
      endfunction

      function void set_threshold(logic reg_sel, logic [SEQ_W-1:0] value);
         if (reg_sel == REG_GAP_LIMIT) begin
            dropout_limit = value;
         end else begin
            misorder_window = value;
         end
      endfunction

      function void open_entry(int idx, logic [SEQ_W-1:0] seq);
         base_seq[idx]  = seq;
         high_seq[idx]  = seq;
         candidate[idx] = NO_CANDIDATE;
         wraps[idx]     = '0;
         rcv_cnt[idx]   = 32'd1;
      endfunction

      function void note_packet(req_item_type pkt);
         tracker_status_type st;
         int                 idx;
         logic [SEQ_W-1:0]   seq;
         logic [SEQ_W-1:0]   hi;
         logic [SEQ_W-1:0]   gap;
         logic [CAND_W-1:0]  jump_limit;
         st  = '0;
         idx = int'(pkt.source_index);
         seq = pkt.sequence_number;
         st.kind = EV_REJECTED;
         if (pkt.mode == MODE_CLEAR) begin
            base_seq[idx]  = '0;
            high_seq[idx]  = '0;
            candidate[idx] = '0;
            wraps[idx]     = '0;
            rcv_cnt[idx]   = '0;
            dup_cnt[idx]   = '0;
            mis_cnt[idx]   = '0;
            st.kind = EV_CLEARED;
         end else if (rcv_cnt[idx] == '0) begin
            open_entry(idx, seq);
            st.accepted = 1'b1;
            st.kind     = EV_FIRST;
         end else begin
            hi  = high_seq[idx];
            gap = seq - hi;
            // a zero window pushes the jump range all the way to 65536
            jump_limit = SEQ_SPAN - {1'b0, misorder_window};
            if (gap < dropout_limit) begin
               if (seq < hi) begin
                  wraps[idx] = wraps[idx] + 16'd1;
                  st.kind    = EV_WRAPPED;
               end else begin
                  st.kind = EV_IN_ORDER;
               end
               high_seq[idx] = seq;
               rcv_cnt[idx]  = rcv_cnt[idx] + 32'd1;
               st.accepted   = 1'b1;
            end else if ({1'b0, gap} <= jump_limit) begin
               if ({1'b0, seq} == candidate[idx]) begin
                  open_entry(idx, seq);
                  st.accepted = 1'b1;
                  st.kind     = EV_RESYNC;
               end else begin
                  candidate[idx] = {1'b0, seq + 16'd1};
               end
            end else begin
               if (gap == '0) begin
                  dup_cnt[idx] = dup_cnt[idx] + 32'd1;
                  st.kind      = EV_DUPLICATE;
               end else begin
                  mis_cnt[idx] = mis_cnt[idx] + 32'd1;
                  st.kind      = EV_MISORDER;
               end
               rcv_cnt[idx] = rcv_cnt[idx] + 32'd1;
               st.accepted  = 1'b1;
            end
         end
         st.ext_highest = {wraps[idx], high_seq[idx]};
         st.first_seq   = base_seq[idx];
         st.received    = rcv_cnt[idx];
         st.duplicates  = dup_cnt[idx];
         st.misordered  = mis_cnt[idx];
         expected_status_q.push_back(st);
      endfunction

      function void check_status(tracker_status_type got);
         tracker_status_type want;
         word_count++;
         if (expected_status_q.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("status word %0d arrived with no packet pending", word_count);
            return;
         end
         want = expected_status_q.pop_front();
         if (got.accepted !== want.accepted || got.kind !== want.kind ||
             got.ext_highest !== want.ext_highest || got.first_seq !== want.first_seq ||
             got.received !== want.received || got.duplicates !== want.duplicates ||
             got.misordered !== want.misordered) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
               $display("word %0d exp: acc=%0d kind=%0d ext=%h first=%h rcv=%0d dup=%0d mis=%0d",
                        word_count, want.accepted, want.kind, want.ext_highest,
                        want.first_seq, want.received, want.duplicates, want.misordered);
               $display("word %0d got: acc=%0d kind=%0d ext=%h first=%h rcv=%0d dup=%0d mis=%0d",
                        word_count, got.accepted, got.kind, got.ext_highest,
                        got.first_seq, got.received, got.duplicates, got.misordered);
            end
         end
      endfunction
   endclass

endpackage

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives packet and clear words into the RTP sequence tracker under random
// valid/ready idling, rewrites both thresholds between phases, and checks
// every status word against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module tb;
   import rtpst_pkg::*;
   import rtpst_tb_pkg::*;

   localparam int CLOCK_PERIOD  = 8;
   localparam int RESET_CYCLES  = 12;
   localparam int PHASE_PACKETS = 200;
   localparam int DRAIN_CYCLES  = 8;
   localparam int HOLD_CYCLES   = 400;
   localparam int CYCLE_LIMIT   = 500000;

   logic                clock;
   logic                reset;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [PADDR_W-1:0]  paddr;
   logic [DATA_W-1:0]   pwdata;
   logic [DATA_W-1:0]   prdata;
   logic                pready;

   rtpst_req_if req_ch ();
   rtpst_rsp_if rsp_ch ();

   seq_status_scoreboard sb;
   bit                   sender_idling   = 1'b0;
   bit                   receiver_idling = 1'b0;
   int unsigned          hold_off_cycles = 0;
   int unsigned          packets_sent    = 0;
   logic [SEQ_W-1:0]     cur_dropout;
   logic [SEQ_W-1:0]     cur_misorder;
   logic [SEQ_W-1:0]     seq_hint [NUM_SOURCES];

   rtp_sequence_tracker_unit u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("rtp_sequence_tracker_unit: mismatch");
      $finish;
   end

   // check before note so a word can never match its own packet
   always @(posedge clock) begin : monitor
      tracker_status_type got;
      req_item_type       pkt;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.accepted    = rsp_ch.accepted;
            got.kind        = rsp_ch.event_kind;
            got.ext_highest = rsp_ch.extended_highest_seq;
            got.first_seq   = rsp_ch.first_seq;
            got.received    = rsp_ch.received_total;
            got.duplicates  = rsp_ch.duplicate_total;
            got.misordered  = rsp_ch.misordered_total;
            sb.check_status(got);
         end
         if (req_ch.valid && req_ch.ready) begin
            pkt.mode            = req_ch.mode;
            pkt.source_index    = req_ch.source_index;
            pkt.sequence_number = req_ch.sequence_number;
            sb.note_packet(pkt);
         end
      end
   end

   initial begin : receiver
      int unsigned n;
      rsp_ch.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (hold_off_cycles != 0) begin
            n = hold_off_cycles;
            hold_off_cycles = 0;
            rsp_ch.ready <= 1'b0;
            repeat (n) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end else if (receiver_idling && $urandom_range(0, 99) < 12) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic send_packet(input logic mode, input logic [SRC_W-1:0] src,
                              input logic [SEQ_W-1:0] seq);
      if (sender_idling && $urandom_range(0, 99) < 20) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_ch.valid           <= 1'b1;
      req_ch.mode            <= mode;
      req_ch.source_index    <= src;
      req_ch.sequence_number <= seq;
      do @(posedge clock); while (!req_ch.ready);
      packets_sent++;
      if (mode == MODE_PACKET)
         seq_hint[src] = seq;
   endtask

   // counts words sent against words checked, independent of monitor order
   task automatic wait_for_drain();
      req_ch.valid <= 1'b0;
      while (sb.word_count != packets_sent) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(input logic reg_sel, input logic [SEQ_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_sel, 2'b00};
      pwdata  <= {16'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      sb.set_threshold(reg_sel, value);
      if (reg_sel == REG_GAP_LIMIT) begin
         cur_dropout = value;
      end else begin
         cur_misorder = value;
      end
   endtask

   // mostly short forward runs on a few busy sources, with boundary gaps,
   // jump/resync pairs, reorders and clears mixed in
   task automatic send_random_packet();
      logic [SRC_W-1:0] src;
      logic [SEQ_W-1:0] h;
      logic [SEQ_W-1:0] seq;
      int unsigned      pick;
      src  = ($urandom_range(0, 99) < 75) ? SRC_W'($urandom_range(0, 7))
                                          : SRC_W'($urandom_range(0, NUM_SOURCES - 1));
      h    = seq_hint[src];
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         send_packet(MODE_PACKET, src, h + SEQ_W'($urandom_range(1, 4)));
      end else if (pick < 48) begin
         send_packet(MODE_PACKET, src, h);
      end else if (pick < 58) begin
         send_packet(MODE_PACKET, src, h - SEQ_W'($urandom_range(1, 150)));
      end else if (pick < 66) begin
         send_packet(MODE_PACKET, src, h + cur_dropout - SEQ_W'($urandom_range(0, 1)));
      end else if (pick < 72) begin
         send_packet(MODE_PACKET, src, h - cur_misorder + SEQ_W'($urandom_range(0, 1)));
      end else if (pick < 86) begin
         seq = $urandom_range(0, 1) ? SEQ_W'($urandom)
                                    : SEQ_W'(16'hFFF0 + $urandom_range(0, 15));
         send_packet(MODE_PACKET, src, seq);
         send_packet(MODE_PACKET, src, seq + 16'd1);
      end else if (pick < 95) begin
         send_packet(MODE_PACKET, src, SEQ_W'($urandom));
      end else begin
         send_packet(MODE_CLEAR, src, SEQ_W'($urandom));
      end
   endtask

   task automatic run_phase(input logic [SEQ_W-1:0] dropout, input logic [SEQ_W-1:0] misorder,
                            input bit s_idle, input bit r_idle, input int unsigned hold);
      int unsigned start;
      wait_for_drain();
      write_threshold(REG_GAP_LIMIT, dropout);
      write_threshold(REG_REORDER_WINDOW, misorder);
      receiver_idling = r_idle;
      hold_off_cycles = hold;
      // keep offering words back to back while the output is held off
      sender_idling = (hold != 0) ? 1'b0 : s_idle;
      start = packets_sent;
      while (packets_sent - start < PHASE_PACKETS) begin
         if (packets_sent - start >= 64)
            sender_idling = s_idle;
         send_random_packet();
      end
   endtask

   initial begin : stimulus
      sb = new();
      reset                  <= 1'b1;
      req_ch.valid           <= 1'b0;
      req_ch.mode            <= MODE_PACKET;
      req_ch.source_index    <= '0;
      req_ch.sequence_number <= '0;
      psel                   <= 1'b0;
      penable                <= 1'b0;
      pwrite                 <= 1'b0;
      paddr                  <= '0;
      pwdata                 <= '0;
      cur_dropout  = GAP_LIMIT_RST;
      cur_misorder = REORDER_WINDOW_RST;
      foreach (seq_hint[i]) seq_hint[i] = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset thresholds: first, wrap, gap boundary, resync, window edge
      send_packet(MODE_PACKET, 6'd63, 16'hFFFF);
      send_packet(MODE_PACKET, 6'd63, 16'd2);
      send_packet(MODE_PACKET, 6'd63, 16'd3001);
      send_packet(MODE_PACKET, 6'd63, 16'd6001);
      send_packet(MODE_PACKET, 6'd63, 16'd6002);
      send_packet(MODE_PACKET, 6'd63, 16'd5902);
      send_packet(MODE_PACKET, 6'd63, 16'd5903);
      send_packet(MODE_PACKET, 6'd63, 16'd6002);
      send_packet(MODE_CLEAR,  6'd63, 16'hFFFF);
      send_packet(MODE_PACKET, 6'd63, 16'd0);
      send_packet(MODE_PACKET, 6'd0,  16'd0);
      send_packet(MODE_PACKET, 6'd0,  16'd0);
      send_packet(MODE_PACKET, 6'd0,  16'd40000);
      send_packet(MODE_PACKET, 6'd0,  16'd40001);
      send_packet(MODE_PACKET, 6'd0,  16'd39990);
      send_packet(MODE_PACKET, 6'd21, 16'hAAAA);
      send_packet(MODE_PACKET, 6'd42, 16'h5555);
      wait_for_drain();

      // zero dropout: an equal number becomes a jump
      write_threshold(REG_GAP_LIMIT, 16'd0);
      send_packet(MODE_PACKET, 6'd0, 16'd40001);
      send_packet(MODE_PACKET, 6'd0, 16'd40002);
      send_packet(MODE_PACKET, 6'd0, 16'd40000);
      wait_for_drain();

      // zero misorder window, widest dropout
      write_threshold(REG_GAP_LIMIT, 16'hFFFF);
      write_threshold(REG_REORDER_WINDOW, 16'd0);
      send_packet(MODE_PACKET, 6'd0, 16'd40001);
      send_packet(MODE_PACKET, 6'd0, 16'd40002);
      wait_for_drain();

      write_threshold(REG_REORDER_WINDOW, 16'hFFFF);
      send_packet(MODE_PACKET, 6'd0, 16'd40001);

      run_phase(GAP_LIMIT_RST, REORDER_WINDOW_RST, 1'b1, 1'b1, 0);
      run_phase(16'd0, 16'd0, 1'b1, 1'b1, HOLD_CYCLES);
      run_phase(16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 0);
      run_phase(16'd1, 16'd1, 1'b1, 1'b0, 0);
      run_phase(SEQ_W'($urandom), SEQ_W'($urandom), 1'b1, 1'b1, 0);
      run_phase(16'd200, 16'd65000, 1'b1, 1'b1, 0);
      run_phase(GAP_LIMIT_RST, REORDER_WINDOW_RST, 1'b0, 1'b0, 0);
      wait_for_drain();

      if (sb.error_count == 0) begin
         $display("rtp_sequence_tracker_unit: match");
      end else begin
         $display("rtp_sequence_tracker_unit: mismatch");
      end
      $finish;
   end

endmodule
